[rtl/mrp_pkg.sv]
// Shared constants, command codes and transfer types of the monochrome raster plotter.
package mrp_pkg;

    localparam int WORDS_PER_ROW = 20;
    localparam int SCREEN_ROWS   = 400;
    localparam int WORD_W        = 32;
    localparam int SCREEN_COLS   = WORDS_PER_ROW * WORD_W;
    localparam int FB_WORDS      = WORDS_PER_ROW * SCREEN_ROWS;
    localparam int ADDR_W        = $clog2(FB_WORDS);
    localparam int CNT_W         = $clog2(FB_WORDS + 1);

    // Field widths of one command.
    localparam int OP_W   = 3;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int LEN_W  = 10;
    localparam int OFF_W  = 5;
    localparam int IDX_W  = 13;

    localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_SPAN   = 3'd1;
    localparam logic [OP_W-1:0] OP_VLINE  = 3'd2;
    localparam logic [OP_W-1:0] OP_BITMAP = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // How each word of a command is applied to the frame buffer.
    typedef enum logic [1:0] {
        MODE_OR,
        MODE_PUT,
        MODE_READ
    } mode_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [COL_W-1:0]  x_pos;
        logic [ROW_W-1:0]  y_pos;
        logic [LEN_W-1:0]  line_length;
        logic [WORD_W-1:0] row_pattern;
        logic [OFF_W-1:0]  row_offset;
        logic [IDX_W-1:0]  word_index;
    } cmd_t;

    // Word walk that the engine executes for one command.
    typedef struct packed {
        mode_t             mode;
        logic [ADDR_W-1:0] addr;
        logic              stride_row;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] first_bits;
        logic [WORD_W-1:0] mid_bits;
        logic [WORD_W-1:0] last_bits;
        logic              status;
    } plan_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              status;
    } res_t;

endpackage

[rtl/monochrome_raster_plotter.sv]
// Top level of the monochrome raster plotter: command and result registers around the engine.
//
// Commands arrive on the s_ stream, one per transfer; each gives exactly one
// result transfer on the m_ stream, in order. The frame buffer is a single
// 8000-word memory; every word touched by a command is written once for
// overwrites (clear, bitmap row), read and then written back for
// read-modify-write (span, vertical line), and only read for a word read.
// A span takes up to 20 words, a vertical line up to 399 rows, a clear
// 8000 words. The memory port paces the block: commands run one at a
// time, and the next one is taken into the command register while the
// current one executes. After reset the block zeroes all 8000 words
// of the buffer; commands wait in the command register meanwhile. When
// the receiver stalls, the result holds in the output register and one
// finished and one queued command more can be held before s_tready drops.
module monochrome_raster_plotter
    import mrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_pos[9:0], y_pos[18:10], line_length[28:19], row_pattern[60:29],
    // row_offset[65:61], word_index[78:66], zero fill[79]
    input  logic [79:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0]
    output logic [31:0] m_tdata,
    // status[0]
    output logic [0:0]  m_tuser
);

    cmd_t              cmd_reg;
    logic              cmd_valid_reg, cmd_valid_next;
    plan_t             plan;
    logic              cmd_take;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;
    logic              s_fire;

    assign s_tready = !cmd_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_take) begin
            cmd_valid_next = 1'b0;
        end
        if (s_fire) begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg.opcode      <= s_tuser;
            cmd_reg.x_pos       <= s_tdata[9:0];
            cmd_reg.y_pos       <= s_tdata[18:10];
            cmd_reg.line_length <= s_tdata[28:19];
            cmd_reg.row_pattern <= s_tdata[60:29];
            cmd_reg.row_offset  <= s_tdata[65:61];
            cmd_reg.word_index  <= s_tdata[78:66];
        end
    end

    mrp_decode u_decode (
        .cmd (cmd_reg),
        .plan(plan)
    );

    mrp_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid_reg),
        .plan     (plan),
        .cmd_take (cmd_take),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res.read_data;
            m_tuser_reg <= res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

[rtl/mrp_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module mrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mrp_decode.sv]
// Range checks and word-walk planning for one plotter command.
module mrp_decode
    import mrp_pkg::*;
(
    input  cmd_t  cmd,
    output plan_t plan
);

    logic              xy_bad;
    logic [10:0]       span_raw;
    logic [10:0]       span_end;
    logic [10:0]       end_m1;
    logic [4:0]        first_w;
    logic [4:0]        last_w;
    logic [5:0]        end_frac;
    logic [WORD_W-1:0] mask_from;
    logic [WORD_W-1:0] mask_to;
    logic [15:0]       y_base;
    logic [9:0]        rows_left;
    logic [9:0]        vcount;
    logic [9:0]        bm_row;
    logic [15:0]       bm_base;
    logic [4:0]        shift;
    logic              bm_two;

    always_comb begin
        xy_bad    = (32'(cmd.x_pos) >= SCREEN_COLS) || (32'(cmd.y_pos) >= SCREEN_ROWS);
        first_w   = cmd.x_pos[9:5];
        shift     = cmd.x_pos[4:0];

        // Span end is clipped at the right edge of the row.
        span_raw  = {1'b0, cmd.x_pos} + {1'b0, cmd.line_length};
        span_end  = (32'(span_raw) > SCREEN_COLS) ? 11'(SCREEN_COLS) : span_raw;
        end_m1    = span_end - 11'd1;
        last_w    = end_m1[9:5];
        end_frac  = {1'b0, end_m1[4:0]} + 6'd1;
        mask_from = WORD_ONES >> shift;
        mask_to   = ~(WORD_ONES >> end_frac);

        y_base    = 16'(cmd.y_pos) * 16'(WORDS_PER_ROW);
        rows_left = 10'(SCREEN_ROWS) - {1'b0, cmd.y_pos};
        vcount    = (cmd.line_length < rows_left) ? cmd.line_length : rows_left;

        bm_row    = {1'b0, cmd.y_pos} + {5'd0, cmd.row_offset};
        bm_base   = 16'(bm_row) * 16'(WORDS_PER_ROW);
        bm_two    = (shift != 5'd0) && (32'({1'b0, first_w} + 6'd1) < WORDS_PER_ROW);

        plan.mode       = MODE_OR;
        plan.addr       = '0;
        plan.stride_row = 1'b0;
        plan.count      = '0;
        plan.first_bits = '0;
        plan.mid_bits   = '0;
        plan.last_bits  = '0;
        plan.status     = 1'b0;

        unique case (cmd.opcode)
            OP_CLEAR: begin
                plan.mode  = MODE_PUT;
                plan.count = CNT_W'(FB_WORDS);
            end
            OP_SPAN: begin
                if (xy_bad || (32'(cmd.line_length) >= SCREEN_COLS)) begin
                    plan.status = 1'b1;
                end else if (cmd.line_length != '0) begin
                    plan.addr       = ADDR_W'(y_base + 16'(first_w));
                    plan.count      = CNT_W'(last_w - first_w) + CNT_W'(1);
                    plan.first_bits = (last_w == first_w) ? (mask_from & mask_to) : mask_from;
                    plan.mid_bits   = WORD_ONES;
                    plan.last_bits  = mask_to;
                end
            end
            OP_VLINE: begin
                if (xy_bad || (32'(cmd.line_length) >= SCREEN_ROWS)) begin
                    plan.status = 1'b1;
                end else begin
                    plan.addr       = ADDR_W'(y_base + 16'(first_w));
                    plan.stride_row = 1'b1;
                    plan.count      = CNT_W'(vcount);
                    plan.first_bits = {1'b1, {(WORD_W-1){1'b0}}} >> shift;
                    plan.mid_bits   = plan.first_bits;
                    plan.last_bits  = plan.first_bits;
                end
            end
            OP_BITMAP: begin
                plan.mode = MODE_PUT;
                if (xy_bad) begin
                    plan.status = 1'b1;
                end else if (32'(bm_row) < SCREEN_ROWS) begin
                    plan.addr       = ADDR_W'(bm_base + 16'(first_w));
                    plan.count      = bm_two ? CNT_W'(2) : CNT_W'(1);
                    plan.first_bits = cmd.row_pattern >> shift;
                    plan.mid_bits   = plan.first_bits;
                    plan.last_bits  = cmd.row_pattern << (6'd32 - {1'b0, shift});
                end
            end
            OP_READ: begin
                plan.mode = MODE_READ;
                plan.addr = ADDR_W'(cmd.word_index);
                if (32'(cmd.word_index) < FB_WORDS) begin
                    plan.count = CNT_W'(1);
                end else begin
                    plan.status = 1'b1;
                end
            end
            default: begin
                plan.status = 1'b1;
            end
        endcase
    end

endmodule

[rtl/mrp_engine.sv]
// Frame buffer memory and the sequencer that walks its words by read-modify-write, overwrite or read.
module mrp_engine
    import mrp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  cmd_valid,
    input  plan_t plan,
    output logic  cmd_take,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_WR   = 6'b000100,
        ST_PUT  = 6'b001000,
        ST_RESP = 6'b010000,
        ST_WIPE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              stride_row_reg, stride_row_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              first_reg, first_next;
    logic [WORD_W-1:0] first_bits_reg, first_bits_next;
    logic [WORD_W-1:0] mid_bits_reg, mid_bits_next;
    logic [WORD_W-1:0] last_bits_reg, last_bits_next;
    logic              status_reg, status_next;
    logic [WORD_W-1:0] rdata_reg, rdata_next;

    logic              mem_we;
    logic              mem_re;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    logic [WORD_W-1:0] step_bits;
    logic [ADDR_W-1:0] addr_step;
    logic              last_step;

    mrp_ram #(
        .WIDTH(WORD_W),
        .DEPTH(FB_WORDS)
    ) u_fb_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(addr_reg),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(addr_reg),
        .rdata(mem_rdata)
    );

    assign step_bits = first_reg ? first_bits_reg :
                       ((remain_reg == CNT_W'(1)) ? last_bits_reg : mid_bits_reg);
    assign addr_step = addr_reg + (stride_row_reg ? ADDR_W'(WORDS_PER_ROW) : ADDR_W'(1));
    assign last_step = (remain_reg == CNT_W'(1));

    assign mem_re    = (state_reg == ST_RD);
    assign mem_we    = ((state_reg == ST_WR) && (mode_reg != MODE_READ)) ||
                       (state_reg == ST_PUT) || (state_reg == ST_WIPE);
    assign mem_wdata = (state_reg == ST_WIPE) ? '0 :
                       (state_reg == ST_PUT)  ? step_bits : (mem_rdata | step_bits);

    assign cmd_take      = (state_reg == ST_IDLE) && cmd_valid;
    assign res_valid     = (state_reg == ST_RESP);
    assign res.read_data = rdata_reg;
    assign res.status    = status_reg;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        stride_row_next = stride_row_reg;
        remain_next     = remain_reg;
        first_next      = first_reg;
        first_bits_next = first_bits_reg;
        mid_bits_next   = mid_bits_reg;
        last_bits_next  = last_bits_reg;
        status_next     = status_reg;
        rdata_next      = rdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    mode_next       = plan.mode;
                    addr_next       = plan.addr;
                    stride_row_next = plan.stride_row;
                    remain_next     = plan.count;
                    first_next      = 1'b1;
                    first_bits_next = plan.first_bits;
                    mid_bits_next   = plan.mid_bits;
                    last_bits_next  = plan.last_bits;
                    status_next     = plan.status;
                    rdata_next      = '0;
                    if (plan.count == '0) begin
                        state_next = ST_RESP;
                    end else if (plan.mode == MODE_PUT) begin
                        state_next = ST_PUT;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                if (mode_reg == MODE_READ) begin
                    rdata_next = mem_rdata;
                end
                addr_next   = addr_step;
                remain_next = remain_reg - CNT_W'(1);
                first_next  = 1'b0;
                state_next  = last_step ? ST_RESP : ST_RD;
            end
            ST_PUT: begin
                addr_next   = addr_step;
                remain_next = remain_reg - CNT_W'(1);
                first_next  = 1'b0;
                state_next  = last_step ? ST_RESP : ST_PUT;
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE: begin
                addr_next   = addr_reg + ADDR_W'(1);
                remain_next = remain_reg - CNT_W'(1);
                state_next  = last_step ? ST_IDLE : ST_WIPE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Reset zeroes the whole buffer before any command is taken.
            state_reg      <= ST_WIPE;
            addr_reg       <= '0;
            remain_reg     <= CNT_W'(FB_WORDS);
            stride_row_reg <= 1'b0;
            first_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            remain_reg     <= remain_next;
            stride_row_reg <= stride_row_next;
            first_reg      <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        first_bits_reg <= first_bits_next;
        mid_bits_reg   <= mid_bits_next;
        last_bits_reg  <= last_bits_next;
        status_reg     <= status_next;
        rdata_reg      <= rdata_next;
    end

endmodule

[rtl/mrp_checker.sv]
// Port-level checks of the monochrome raster plotter, bound to its top level.
module mrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic [2:0] pend_reg, pend_next;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg + 3'(s_fire) - 3'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Every result transfer answers an earlier command transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |-> pend_reg != 3'd0)
        else $error("result without a pending command");

    // Command, engine and output register hold at most three commands in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == 3'd3 |-> !s_tready)
        else $error("command taken with all stages full");

    // A rejected command never carries read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("rejected result with nonzero data");

endmodule

bind monochrome_raster_plotter mrp_checker u_mrp_checker (.*);
